FILE: src/itoa_fmt_pkg.sv
`timescale 1ns / 1ps
package itoa_fmt_pkg;
    localparam logic [1:0] CMD_SDEC = 2'd0;
    localparam logic [1:0] CMD_UDEC = 2'd1;
    localparam logic [1:0] CMD_HEX  = 2'd2;
    localparam logic [1:0] CMD_NOP  = 2'd3;
    localparam int unsigned MAX_CHARS = 16;
    localparam int unsigned DEC_DIGITS = 10;
    localparam logic [7:0] ASCII_ZERO   = 8'd48;
    localparam logic [7:0] ASCII_LETTER = 8'd87;
    localparam logic [7:0] ASCII_MINUS  = 8'd45;

    typedef logic [3:0] t_nib;
    typedef t_nib [MAX_CHARS-1:0] t_digits;

    // Shift-add-3 correction of one BCD digit.
    function automatic t_nib add3(input t_nib d);
        add3 = (d >= 4'd5) ? t_nib'(d + 4'd3) : d;
    endfunction
endpackage

FILE: src/itoa_fmt_dd.sv
`timescale 1ns / 1ps
// One pipeline stage of double dabble: shift STEPS bits of the binary
// word into the BCD digits.
module itoa_fmt_dd #(
    parameter int STEPS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_vld,
    input  logic [31:0]            i_bin,
    input  itoa_fmt_pkg::t_digits  i_bcd,
    output logic                   o_vld,
    output logic [31:0]            o_bin,
    output itoa_fmt_pkg::t_digits  o_bcd
);
    import itoa_fmt_pkg::*;
    logic [31:0] n_bin;
    t_digits     n_bcd;
    logic [31:0] r_bin;
    t_digits     r_bcd;
    logic        r_vld;

    always_comb begin
        n_bin = i_bin;
        n_bcd = i_bcd;
        for (int s = 0; s < STEPS; s++) begin
            for (int d = 0; d < DEC_DIGITS; d++) n_bcd[d] = add3(n_bcd[d]);
            for (int d = DEC_DIGITS - 1; d > 0; d--)
                n_bcd[d] = {n_bcd[d][2:0], n_bcd[d-1][3]};
            n_bcd[0] = {n_bcd[0][2:0], n_bin[31]};
            n_bin = {n_bin[30:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
        if (i_en) begin
            r_bin <= n_bin;
            r_bcd <= n_bcd;
        end
    end

    assign o_vld = r_vld;
    assign o_bin = r_bin;
    assign o_bcd = r_bcd;
endmodule

FILE: src/integer_to_ascii_formatter_core.sv
`timescale 1ns / 1ps
// Integer to ASCII formatter.
// Input channel (i_valid/o_ready): one word holds a mode (i_cmd) and a
// 64-bit number (i_value). Mode 0 prints the low 32 bits as signed decimal,
// mode 1 as unsigned decimal, mode 2 prints all 64 bits as lowercase hex.
// Mode 3 words are taken and dropped with no output.
// Output channel (o_valid/i_ready): one character per word, most significant
// first, no leading zeros; the final character has o_last_char set and
// o_char_count holds the string length (1..16), zero on other characters.
// Pipeline: a word passes a front stage that forms the magnitude, four
// double-dabble stages (8 bits each), and lands in the emit register.
// Throughput: the emit register sends one character per cycle while i_ready
// is high; the pipeline advances only when the emit register is free, so
// words behind queue up.
// Stall: with i_ready low and a character waiting, the pipeline holds; nothing is lost or repeated.
// Reset clears all valid bits; no word is in flight afterwards.
module integer_to_ascii_formatter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [63:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_ascii_char,
    output logic        o_last_char,
    output logic [4:0]  o_char_count
);
    import itoa_fmt_pkg::*;

    localparam int NSTG = 4;

    // Emit register: digits, count, index, sign.
    logic        r_e_vld;
    t_digits     r_e_dig;
    logic [4:0]  r_e_cnt;
    logic [4:0]  r_e_idx;
    logic        r_e_neg;
    logic        adv;
    logic        e_done;

    assign e_done = r_e_vld && i_ready && (r_e_idx == r_e_cnt - 5'd1);
    assign adv    = !r_e_vld || e_done;
    assign o_ready = adv;

    // Front stage: drop unused mode, form magnitude.
    logic        r_f_vld;
    logic        r_f_neg;
    logic        r_f_hex;
    logic [63:0] r_f_val;
    logic [31:0] n_mag;

    always_comb begin
        n_mag = i_value[31:0];
        if (i_cmd == CMD_SDEC && i_value[31]) n_mag = 32'(~i_value[31:0] + 32'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (adv) begin
            r_f_vld <= i_valid && (i_cmd != CMD_NOP);
        end
        if (adv) begin
            r_f_neg <= (i_cmd == CMD_SDEC) && i_value[31];
            r_f_hex <= (i_cmd == CMD_HEX);
            r_f_val <= {i_value[63:32], (i_cmd == CMD_HEX) ? i_value[31:0] : n_mag};
        end
    end

    // Double-dabble stages; hex and sign ride alongside.
    logic [NSTG:0]      s_vld;
    logic [31:0]        s_bin [NSTG+1];
    t_digits            s_bcd [NSTG+1];
    logic [NSTG-1:0]    r_s_neg;
    logic [NSTG-1:0]    r_s_hex;
    logic [63:0]        r_s_val [NSTG];

    assign s_vld[0] = r_f_vld;
    assign s_bin[0] = r_f_val[31:0];
    assign s_bcd[0] = '0;

    for (genvar g = 0; g < NSTG; g++) begin : g_dd
        itoa_fmt_dd #(.STEPS(32 / NSTG)) u_dd (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv),
            .i_vld(s_vld[g]), .i_bin(s_bin[g]), .i_bcd(s_bcd[g]),
            .o_vld(s_vld[g+1]), .o_bin(s_bin[g+1]), .o_bcd(s_bcd[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s_neg    <= {r_s_neg[NSTG-2:0], r_f_neg};
            r_s_hex    <= {r_s_hex[NSTG-2:0], r_f_hex};
            r_s_val[0] <= r_f_val;
            for (int g = 1; g < NSTG; g++) r_s_val[g] <= r_s_val[g-1];
        end
    end

    // Digit select and leading-zero count for the emit register.
    t_digits    n_dig;
    logic [4:0] n_nd;

    always_comb begin
        if (r_s_hex[NSTG-1]) begin
            for (int d = 0; d < MAX_CHARS; d++) n_dig[d] = r_s_val[NSTG-1][4*d +: 4];
        end else begin
            n_dig = s_bcd[NSTG];
        end
        n_nd = 5'd1;
        for (int d = 1; d < MAX_CHARS; d++) if (n_dig[d] != 4'd0) n_nd = 5'(d + 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (adv) begin
            r_e_vld <= s_vld[NSTG];
        end
        if (adv) begin
            r_e_dig <= n_dig;
            r_e_neg <= r_s_neg[NSTG-1];
            r_e_cnt <= 5'(n_nd + {4'd0, r_s_neg[NSTG-1]});
            r_e_idx <= 5'd0;
        end else if (r_e_vld && i_ready) begin
            r_e_idx <= r_e_idx + 5'd1;
        end
    end

    // Character at current index.
    logic [4:0] pos;
    t_nib       dig;
    assign pos = r_e_cnt - 5'd1 - r_e_idx;
    assign dig = r_e_dig[pos[3:0]];

    always_comb begin
        if (r_e_neg && r_e_idx == 5'd0) begin
            o_ascii_char = ASCII_MINUS;
        end else if (dig < 4'd10) begin
            o_ascii_char = ASCII_ZERO + {4'd0, dig};
        end else begin
            o_ascii_char = ASCII_LETTER + {4'd0, dig};
        end
    end

    assign o_valid      = r_e_vld;
    assign o_last_char  = (r_e_idx == r_e_cnt - 5'd1);
    assign o_char_count = o_last_char ? r_e_cnt : 5'd0;
endmodule

FILE: tb/integer_to_ascii_formatter_core_tb.sv
`timescale 1ns / 1ps
module integer_to_ascii_formatter_core_tb;
    import itoa_fmt_pkg::*;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] value;
    } t_num;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic [4:0] count;
    } t_char;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_cmd = '0;
    logic [63:0] i_value = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_ascii_char;
    logic        o_last_char;
    logic [4:0]  o_char_count;

    t_num  num_q[$];
    t_char char_q[$];
    int    errors = 0;
    int    gap_left = 0;
    int    burst_left = 0;
    bit    drain_hold = 1'b0;
    bit    stim_done = 1'b0;
    int    stall_phase = 0;

    integer_to_ascii_formatter_core dut (.*);

    always #2 i_clk = ~i_clk;

    // Queue the characters that one number should print.
    function automatic void format_number(input t_num n);
        logic [63:0] mag;
        logic [63:0] base;
        logic [7:0]  rev[16];
        logic [7:0]  seq[16];
        logic [63:0] d;
        int nd;
        int tot;
        t_char c;
        nd = 0;
        tot = 0;
        if (n.cmd == CMD_NOP) return;
        if (n.cmd == CMD_SDEC) begin
            base = 64'd10;
            if (n.value[31]) begin
                seq[tot++] = ASCII_MINUS;
                mag = {32'd0, ~n.value[31:0] + 32'd1};
                if (mag == 0) mag = 64'h8000_0000;
            end else begin
                mag = {32'd0, n.value[31:0]};
            end
        end else if (n.cmd == CMD_UDEC) begin
            base = 64'd10;
            mag = {32'd0, n.value[31:0]};
        end else begin
            base = 64'd16;
            mag = n.value;
        end
        do begin
            d = mag % base;
            rev[nd++] = (d < 10) ? 8'(d) + ASCII_ZERO : 8'(d) + ASCII_LETTER;
            mag = mag / base;
        end while (mag != 0 && nd < 16);
        for (int k = 0; k < nd && tot < 16; k++) seq[tot++] = rev[nd-1-k];
        for (int k = 0; k < tot; k++) begin
            c.ch = seq[k];
            c.last = (k + 1 == tot);
            c.count = c.last ? 5'(tot) : 5'd0;
            char_q.push_back(c);
        end
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Driver: bursts and gaps, plus one full drain pause midway.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                format_number('{cmd: i_cmd, value: i_value});
            end
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid <= 1'b0;
                end else if (num_q.size() == 0) begin
                    i_valid <= 1'b0;
                    stim_done <= 1'b1;
                end else if (num_q.size() == 200 && !drain_hold
                             && (char_q.size() > 0 || (i_valid && o_ready))) begin
                    // hold until every expected character has come
                    i_valid <= 1'b0;
                end else begin
                    if (num_q.size() == 200) drain_hold <= 1'b1;
                    {i_cmd, i_value} <= num_q.pop_front();
                    i_valid <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 20);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // Receiver: stall pattern with quiet stretches.
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if ((stall_phase / 300) % 3 == 0) i_ready <= 1'b1;
        else i_ready <= ($urandom_range(0, 3) != 0) && (stall_phase % 7 != 3);
    end

    // Monitor: compare each character word with the oldest expectation.
    always @(posedge i_clk) begin
        t_char e;
        if (i_rst_n && o_valid && i_ready) begin
            if (char_q.size() == 0) begin
                $display("%0t: unexpected char act=%h last=%b cnt=%0d", $realtime,
                         o_ascii_char, o_last_char, o_char_count);
                errors++;
            end else begin
                e = char_q.pop_front();
                if (e.ch !== o_ascii_char || e.last !== o_last_char
                    || e.count !== o_char_count) begin
                    $display("%0t: mismatch exp=%h/%b/%0d act=%h/%b/%0d", $realtime,
                             e.ch, e.last, e.count, o_ascii_char, o_last_char,
                             o_char_count);
                    errors++;
                end
            end
        end
    end

    initial begin
        t_num n;
        logic [63:0] dir[$];
        dir = '{64'd0, 64'hFFFF_FFFF, 64'h8000_0000, 64'h7FFF_FFFF,
                64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'd9, 64'd10};
        foreach (dir[i]) begin
            num_q.push_back('{cmd: CMD_SDEC, value: dir[i]});
            num_q.push_back('{cmd: CMD_UDEC, value: dir[i]});
            num_q.push_back('{cmd: CMD_HEX, value: dir[i]});
        end
        num_q.push_back('{cmd: CMD_NOP, value: 64'd123});
        for (int i = 0; i < 350; i++) begin
            n.cmd = $urandom_range(0, 9) == 0 ? CMD_NOP : 2'($urandom_range(0, 2));
            case ($urandom_range(0, 3))
                0: n.value = rand64() >> $urandom_range(0, 63);
                1: n.value = 64'($urandom_range(0, 20));
                default: n.value = rand64();
            endcase
            num_q.push_back(n);
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done && char_q.size() == 0);
        repeat (50) @(posedge i_clk);
        if (errors == 0 && char_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end
endmodule
